@@ sv/ksch_pkg.sv @@
// ----------------------------------------------------------------------------
// ksch_pkg
// Shared constants for the limited-count weighted interval scheduler.
// ----------------------------------------------------------------------------
package ksch_pkg;

  // Width of the start, end and weight fields of one interval.
  localparam int unsigned FIELD_W = 30;

  // Width of one stored key: start, end and weight side by side.
  localparam int unsigned KEY_W = 3 * FIELD_W;

  // Width of the picked_index result field.
  localparam int unsigned PICK_OUT_W = 10;

  // Default sizing of the block.
  localparam int unsigned DEF_MAX_INTERVALS = 1024;
  localparam int unsigned DEF_MAX_PICK = 4;

endpackage

@@ sv/ksch_row_update.sv @@
// ----------------------------------------------------------------------------
// ksch_row_update
// Computes one table row from the row just below it (interval skipped) and
// the row at the successor position (interval taken), for every pick count.
// ----------------------------------------------------------------------------
module ksch_row_update #(
  parameter int unsigned MAX_PICK = ksch_pkg::DEF_MAX_PICK,
  parameter int unsigned INDEX_W = 10,
  localparam int unsigned LEN_W = $clog2(MAX_PICK + 1),
  localparam int unsigned SCORE_W = ksch_pkg::FIELD_W + LEN_W,
  localparam int unsigned CELL_W = SCORE_W + LEN_W + MAX_PICK * INDEX_W,
  localparam int unsigned ROW_W = (MAX_PICK + 1) * CELL_W
) (
  input  logic [ROW_W-1:0]                skip_row,
  input  logic [ROW_W-1:0]                from_row,
  input  logic [ksch_pkg::FIELD_W-1:0]    weight,
  input  logic [INDEX_W-1:0]              id,
  output logic [ROW_W-1:0]                new_row
);

  logic [SCORE_W-1:0] f_score;
  logic [SCORE_W-1:0] s_score;
  logic [SCORE_W-1:0] take_score;
  logic [LEN_W-1:0]   f_len;
  logic [LEN_W-1:0]   s_len;
  logic [LEN_W-1:0]   c_len;
  logic [LEN_W-1:0]   m_len;
  logic [LEN_W-1:0]   ins;
  logic [INDEX_W-1:0] f_ids [MAX_PICK];
  logic [INDEX_W-1:0] s_ids [MAX_PICK];
  logic [INDEX_W-1:0] c_ids [MAX_PICK];
  logic               done;
  logic               less;
  logic               use_take;
  logic [CELL_W-1:0]  take_entry;

  // Each pick count is an independent cell; cell zero stays empty.
  always_comb begin
    new_row = '0;
    for (int k = 1; k <= MAX_PICK; k++) begin
      f_score = from_row[(k-1)*CELL_W +: SCORE_W];
      f_len = from_row[(k-1)*CELL_W + SCORE_W +: LEN_W];
      s_score = skip_row[k*CELL_W +: SCORE_W];
      s_len = skip_row[k*CELL_W + SCORE_W +: LEN_W];
      for (int p = 0; p < MAX_PICK; p++) begin
        f_ids[p] = from_row[(k-1)*CELL_W + SCORE_W + LEN_W + p*INDEX_W +: INDEX_W];
        s_ids[p] = skip_row[k*CELL_W + SCORE_W + LEN_W + p*INDEX_W +: INDEX_W];
      end

      // Insert this interval's arrival number into the taken list in order.
      ins = '0;
      for (int p = 0; p < MAX_PICK; p++) begin
        if (LEN_W'(p) < f_len && f_ids[p] < id) begin
          ins = ins + 1'b1;
        end
      end
      for (int p = 0; p < MAX_PICK; p++) begin
        if (LEN_W'(p) < ins) begin
          c_ids[p] = f_ids[p];
        end else if (LEN_W'(p) == ins) begin
          c_ids[p] = id;
        end else begin
          c_ids[p] = f_ids[(p == 0) ? 0 : p - 1];
        end
      end
      c_len = f_len + 1'b1;
      take_score = f_score + SCORE_W'(weight);

      // Lexicographic compare of the skipped list against the taken list.
      m_len = (s_len < c_len) ? s_len : c_len;
      done = 1'b0;
      less = 1'b0;
      for (int p = 0; p < MAX_PICK; p++) begin
        if (!done && LEN_W'(p) < m_len && s_ids[p] != c_ids[p]) begin
          less = s_ids[p] < c_ids[p];
          done = 1'b1;
        end
      end
      if (!done) begin
        less = s_len < c_len;
      end
      use_take = (take_score != s_score) ? (take_score > s_score) : !less;

      // Assemble the winning cell.
      take_entry = '0;
      take_entry[SCORE_W-1:0] = take_score;
      take_entry[SCORE_W +: LEN_W] = c_len;
      for (int p = 0; p < MAX_PICK; p++) begin
        take_entry[SCORE_W + LEN_W + p*INDEX_W +: INDEX_W] = c_ids[p];
      end
      new_row[k*CELL_W +: CELL_W] = use_take ? take_entry : skip_row[k*CELL_W +: CELL_W];
    end
  end

endmodule

@@ sv/k_limited_interval_scheduling_top.sv @@
// ----------------------------------------------------------------------------
// k_limited_interval_scheduling_top
// Picks at most MAX_PICK non-overlapping weighted intervals of greatest total.
// ----------------------------------------------------------------------------
// Intervals load at one item per cycle into the key memory. The item flagged
// last closes the set of n intervals; the block then stalls its input while it
// ranks every interval by a full scan of the key memory (one key read per
// cycle), finds each successor by binary search in the sorted memory, and fills
// the table one row at a time from the last row up. The picked arrival numbers
// then leave one per cycle while the receiver does not stall, in ascending
// order, and loading resumes after the final one.
module k_limited_interval_scheduling_top #(
  parameter int unsigned MAX_INTERVALS = ksch_pkg::DEF_MAX_INTERVALS,
  parameter int unsigned MAX_PICK = ksch_pkg::DEF_MAX_PICK
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [ksch_pkg::FIELD_W-1:0]  interval_start,
  input  logic [ksch_pkg::FIELD_W-1:0]  interval_end,
  input  logic [ksch_pkg::FIELD_W-1:0]  interval_weight,
  input  logic                          last_interval,
  output logic                          pick_valid,
  input  logic                          pick_stall,
  output logic [ksch_pkg::PICK_OUT_W-1:0] picked_index,
  output logic                          none_picked,
  output logic                          last_pick
);

  localparam int unsigned FW = ksch_pkg::FIELD_W;
  localparam int unsigned KW = ksch_pkg::KEY_W;
  localparam int unsigned IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned SRT_W = KW + IW;
  localparam int unsigned LEN_W = $clog2(MAX_PICK + 1);
  localparam int unsigned SCORE_W = FW + LEN_W;
  localparam int unsigned CELL_W = SCORE_W + LEN_W + MAX_PICK * IW;
  localparam int unsigned ROW_W = (MAX_PICK + 1) * CELL_W;

  typedef enum logic [13:0] {
    ST_LOAD    = 14'b00000000000001,
    ST_RK_A    = 14'b00000000000010,
    ST_RK_B    = 14'b00000000000100,
    ST_RK_C    = 14'b00000000001000,
    ST_RK_W    = 14'b00000000010000,
    ST_SR_A    = 14'b00000000100000,
    ST_SR_B    = 14'b00000001000000,
    ST_SR_C    = 14'b00000010000000,
    ST_SR_D    = 14'b00000100000000,
    ST_DP_INIT = 14'b00001000000000,
    ST_DP_A    = 14'b00010000000000,
    ST_DP_B    = 14'b00100000000000,
    ST_DP_C    = 14'b01000000000000,
    ST_EMIT    = 14'b10000000000000
  } state_t;

  state_t state;

  // Memories.
  logic [KW-1:0]    key_mem [MAX_INTERVALS];
  logic [SRT_W-1:0] srt_mem [MAX_INTERVALS];
  logic [CW-1:0]    nxt_mem [MAX_INTERVALS];
  logic [ROW_W-1:0] dp_mem  [MAX_INTERVALS + 1];

  logic [IW-1:0]    key_raddr;
  logic [KW-1:0]    key_rdata;
  logic [IW-1:0]    srt_raddr;
  logic [SRT_W-1:0] srt_rdata;
  logic [CW-1:0]    nxt_rdata;
  logic [ROW_W-1:0] dp_rdata;

  // Control and working registers.
  logic [CW-1:0]    load_count;
  logic [CW-1:0]    n;
  logic [CW-1:0]    ri;
  logic [CW-1:0]    rj;
  logic [CW-1:0]    rank;
  logic [CW-1:0]    si;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic [CW-1:0]    mid_r;
  logic [CW-1:0]    di;
  logic [LEN_W-1:0] ei;
  logic [KW-1:0]    key_i;
  logic [FW-1:0]    limit;
  logic [FW-1:0]    cur_w;
  logic [IW-1:0]    cur_id;
  logic [ROW_W-1:0] prev_row;
  logic [ROW_W-1:0] new_row;

  logic             item_acc;
  logic             pick_acc;
  logic             key_less;
  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    succ;
  logic [LEN_W-1:0] res_len;
  logic [IW-1:0]    res_id;

  assign item_stall = (state != ST_LOAD);
  assign item_acc = item_valid && !item_stall;
  assign pick_acc = pick_valid && !pick_stall;

  // Rank compare: key order then arrival number, as one wide compare.
  assign key_less = {key_rdata, rj[IW-1:0]} < {key_i, ri[IW-1:0]};

  // Binary search midpoint and successor choice.
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[CW:1];
  assign succ = (lo > si) ? lo : si + 1'b1;

  // Final result list from row zero, pick count MAX_PICK.
  assign res_len = prev_row[MAX_PICK*CELL_W + SCORE_W +: LEN_W];
  assign res_id = prev_row[MAX_PICK*CELL_W + SCORE_W + LEN_W + ei*IW +: IW];

  // Read address selection.
  always_comb begin
    unique case (state)
      ST_RK_A: key_raddr = ri[IW-1:0];
      ST_RK_C: key_raddr = IW'(rj + 1'b1);
      default: key_raddr = '0;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_SR_A: srt_raddr = si[IW-1:0];
      ST_SR_C: srt_raddr = mid[IW-1:0];
      default: srt_raddr = di[IW-1:0];
    endcase
  end

  // Key memory: written during loading, scanned during ranking.
  always_ff @(posedge clk) begin
    if (item_acc && load_count < CW'(MAX_INTERVALS)) begin
      key_mem[load_count[IW-1:0]] <= {interval_start, interval_end, interval_weight};
    end
    key_rdata <= key_mem[key_raddr];
  end

  // Sorted memory: one entry per rank position.
  always_ff @(posedge clk) begin
    if (state == ST_RK_W) begin
      srt_mem[rank[IW-1:0]] <= {key_i, ri[IW-1:0]};
    end
    srt_rdata <= srt_mem[srt_raddr];
  end

  // Successor memory.
  always_ff @(posedge clk) begin
    if (state == ST_SR_C && !(lo < hi)) begin
      nxt_mem[si[IW-1:0]] <= succ;
    end
    nxt_rdata <= nxt_mem[di[IW-1:0]];
  end

  // Table memory: one row of cells per sorted position.
  always_ff @(posedge clk) begin
    if (state == ST_DP_INIT) begin
      dp_mem[n] <= '0;
    end else if (state == ST_DP_C) begin
      dp_mem[di] <= new_row;
    end
    dp_rdata <= dp_mem[nxt_rdata];
  end

  ksch_row_update #(
    .MAX_PICK (MAX_PICK),
    .INDEX_W  (IW)
  ) u_row_update (
    .skip_row (prev_row),
    .from_row (dp_rdata),
    .weight   (cur_w),
    .id       (cur_id),
    .new_row  (new_row)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_RK_B) begin
      key_i <= key_rdata;
    end
    if (state == ST_SR_B) begin
      limit <= srt_rdata[IW + FW +: FW];
    end
    if (state == ST_SR_C) begin
      mid_r <= mid;
    end
    if (state == ST_DP_B) begin
      cur_w <= srt_rdata[IW +: FW];
      cur_id <= srt_rdata[IW-1:0];
    end
    if (state == ST_DP_INIT) begin
      prev_row <= '0;
    end else if (state == ST_DP_C) begin
      prev_row <= new_row;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      load_count <= '0;
      n <= '0;
      ri <= '0;
      rj <= '0;
      rank <= '0;
      si <= '0;
      lo <= '0;
      hi <= '0;
      di <= '0;
      ei <= '0;
      pick_valid <= 1'b0;
      picked_index <= '0;
      none_picked <= 1'b0;
      last_pick <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (item_acc) begin
            if (last_interval) begin
              n <= (load_count < CW'(MAX_INTERVALS)) ? load_count + 1'b1 : load_count;
              load_count <= '0;
              ri <= '0;
              state <= ST_RK_A;
            end else if (load_count < CW'(MAX_INTERVALS)) begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_RK_A: begin
          state <= ST_RK_B;
        end
        ST_RK_B: begin
          rj <= '0;
          rank <= '0;
          state <= ST_RK_C;
        end
        ST_RK_C: begin
          if (key_less) begin
            rank <= rank + 1'b1;
          end
          rj <= rj + 1'b1;
          if (rj == n - 1'b1) begin
            state <= ST_RK_W;
          end
        end
        ST_RK_W: begin
          ri <= ri + 1'b1;
          if (ri == n - 1'b1) begin
            si <= '0;
            state <= ST_SR_A;
          end else begin
            state <= ST_RK_A;
          end
        end
        ST_SR_A: begin
          state <= ST_SR_B;
        end
        ST_SR_B: begin
          lo <= '0;
          hi <= n;
          state <= ST_SR_C;
        end
        ST_SR_C: begin
          if (lo < hi) begin
            state <= ST_SR_D;
          end else begin
            si <= si + 1'b1;
            if (si == n - 1'b1) begin
              state <= ST_DP_INIT;
            end else begin
              state <= ST_SR_A;
            end
          end
        end
        ST_SR_D: begin
          if (srt_rdata[IW + 2*FW +: FW] > limit) begin
            hi <= mid_r;
          end else begin
            lo <= mid_r + 1'b1;
          end
          state <= ST_SR_C;
        end
        ST_DP_INIT: begin
          di <= n - 1'b1;
          state <= ST_DP_A;
        end
        ST_DP_A: begin
          state <= ST_DP_B;
        end
        ST_DP_B: begin
          state <= ST_DP_C;
        end
        ST_DP_C: begin
          if (di == '0) begin
            ei <= '0;
            state <= ST_EMIT;
          end else begin
            di <= di - 1'b1;
            state <= ST_DP_A;
          end
        end
        ST_EMIT: begin
          // Present the next item once the output register is free.
          if (!pick_valid || !pick_stall) begin
            if (pick_valid && last_pick) begin
              pick_valid <= 1'b0;
              state <= ST_LOAD;
            end else begin
              pick_valid <= 1'b1;
              picked_index <= ksch_pkg::PICK_OUT_W'(32'(res_id));
              none_picked <= (res_len == '0);
              last_pick <= (res_len == '0) || (ei + 1'b1 == res_len);
              ei <= ei + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Results appear only after the table pass is complete.
  a_pick_in_emit: assert property (@(posedge clk) disable iff (rst)
    pick_valid |-> state == ST_EMIT)
    else $error("result item outside the emit phase");

  // An empty choice is always the only item of its run.
  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (pick_valid && none_picked) |-> last_pick)
    else $error("empty choice not flagged as final item");

  // Once the final item is taken, no further item follows.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (pick_acc && last_pick) |=> !pick_valid)
    else $error("item emitted after final item of the run");

  // A rank never reaches the interval count.
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RK_W |-> rank < n)
    else $error("rank out of range");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the limited-count weighted interval scheduler.
// ----------------------------------------------------------------------------
// Intervals are sent as sets closed by an item flagged last. The bench keeps
// its own copy of every set. When a set closes, it sorts the set, finds each
// successor, fills the pick table, and queues the expected picks. Every pick
// the block hands out is checked against the oldest expected pick. A short
// table of directed items comes first. Random sets follow. Both sides idle at
// random, and the receiver holds off once for a long stretch while the next
// item waits.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FIELD_W = ksch_pkg::FIELD_W;
  localparam int unsigned PICK_OUT_W = ksch_pkg::PICK_OUT_W;
  localparam int unsigned MAX_IV = ksch_pkg::DEF_MAX_INTERVALS;
  localparam int unsigned MAX_PK = ksch_pkg::DEF_MAX_PICK;
  localparam int unsigned ROW_W = MAX_PK + 1;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam longint unsigned CYCLE_LIMIT = 8000000;

  typedef struct {
    logic [PICK_OUT_W-1:0] idx;
    logic                  none;
    logic                  last;
  } pick_t;

  typedef struct packed {
    logic [FIELD_W-1:0]    s;
    logic [FIELD_W-1:0]    e;
    logic [FIELD_W-1:0]    w;
    logic                  lst;
    logic                  known;
    logic [PICK_OUT_W-1:0] idx;
    logic                  none;
  } dir_row_t;

  typedef int unsigned pick_list_t[MAX_PK];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [FIELD_W-1:0] interval_start = '0;
  logic [FIELD_W-1:0] interval_end = '0;
  logic [FIELD_W-1:0] interval_weight = '0;
  logic last_interval = 1'b0;
  logic pick_valid;
  logic pick_stall = 1'b0;
  logic [PICK_OUT_W-1:0] picked_index;
  logic none_picked;
  logic last_pick;

  // Intervals of the open set, in arrival order.
  logic [FIELD_W-1:0] set_start[$];
  logic [FIELD_W-1:0] set_end[$];
  logic [FIELD_W-1:0] set_weight[$];

  pick_t expected_picks[$];
  int unsigned mismatches = 0;
  int unsigned picks_seen = 0;
  longint unsigned cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_done = 1'b0;

  k_limited_interval_scheduling_top u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .interval_start(interval_start),
    .interval_end(interval_end),
    .interval_weight(interval_weight),
    .last_interval(last_interval),
    .pick_valid(pick_valid),
    .pick_stall(pick_stall),
    .picked_index(picked_index),
    .none_picked(none_picked),
    .last_pick(last_pick)
  );

  always #4 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("k_limited_interval_scheduling_top test failed");
      $finish;
    end
  end

  // Lexicographic comparison of two ascending pick lists; a proper prefix
  // counts as smaller.
  function automatic bit list_below(pick_list_t a, int unsigned la,
                                    pick_list_t b, int unsigned lb);
    int unsigned m;
    m = (la < lb) ? la : lb;
    for (int unsigned i = 0; i < m; i++)
      if (a[i] != b[i]) return a[i] < b[i];
    return la < lb;
  endfunction

  // Solves the closed set and queues its picks in ascending order.
  task automatic solve_set(input bit typed, input pick_t typed_pick);
    int unsigned n, j, lo, hi, mid, here, nxt_row, skip, from, cl, id;
    int unsigned order[];
    int unsigned succ[];
    longint unsigned best[];
    int unsigned plen[];
    pick_list_t plist[];
    pick_list_t cand;
    longint unsigned take_score, skip_score;
    logic [3*FIELD_W-1:0] key_j, key_p;
    bit put, take;
    pick_t pk;
    n = set_start.size();
    order = new[n];
    succ = new[n];
    best = new[(n + 1) * ROW_W];
    plen = new[(n + 1) * ROW_W];
    plist = new[(n + 1) * ROW_W];
    // Stable insertion sort on start, end, weight; arrival breaks ties.
    for (int unsigned i = 0; i < n; i++) begin
      j = i;
      key_j = {set_start[i], set_end[i], set_weight[i]};
      while (j > 0) begin
        key_p = {set_start[order[j-1]], set_end[order[j-1]], set_weight[order[j-1]]};
        if (key_p <= key_j) break;
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    // Successor: first sorted interval starting after this one's end.
    for (int unsigned i = 0; i < n; i++) begin
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (set_start[order[mid]] > set_end[order[i]]) hi = mid;
        else lo = mid + 1;
      end
      succ[i] = (lo > i) ? lo : i + 1;
    end
    for (int unsigned k = 0; k <= MAX_PK; k++) begin
      best[n*ROW_W + k] = 0;
      plen[n*ROW_W + k] = 0;
    end
    // Table pass from the last sorted interval up.
    for (int i = n - 1; i >= 0; i--) begin
      here = i * ROW_W;
      id = order[i];
      nxt_row = succ[i] * ROW_W;
      best[here] = 0;
      plen[here] = 0;
      for (int unsigned k = 1; k <= MAX_PK; k++) begin
        skip = (i + 1) * ROW_W + k;
        from = nxt_row + k - 1;
        take_score = best[from] + set_weight[order[i]];
        skip_score = best[skip];
        cl = 0;
        put = 1'b0;
        for (int unsigned p = 0; p < plen[from]; p++) begin
          if (!put && id < plist[from][p]) begin
            cand[cl] = id;
            cl++;
            put = 1'b1;
          end
          cand[cl] = plist[from][p];
          cl++;
        end
        if (!put) begin
          cand[cl] = id;
          cl++;
        end
        if (take_score != skip_score) take = take_score > skip_score;
        else take = !list_below(plist[skip], plen[skip], cand, cl);
        if (take) begin
          best[here + k] = take_score;
          plen[here + k] = cl;
          plist[here + k] = cand;
        end else begin
          best[here + k] = skip_score;
          plen[here + k] = plen[skip];
          plist[here + k] = plist[skip];
        end
      end
    end
    if (typed) begin
      expected_picks = {expected_picks, typed_pick};
    end else if (plen[MAX_PK] == 0) begin
      pk.idx = '0;
      pk.none = 1'b1;
      pk.last = 1'b1;
      expected_picks = {expected_picks, pk};
    end else begin
      for (int unsigned r = 0; r < plen[MAX_PK]; r++) begin
        pk.idx = plist[MAX_PK][r][PICK_OUT_W-1:0];
        pk.none = 1'b0;
        pk.last = (r + 1 == plen[MAX_PK]);
        expected_picks = {expected_picks, pk};
      end
    end
    set_start.delete();
    set_end.delete();
    set_weight.delete();
  endtask

  // Offers one item, waits for it to be taken, then updates the open set.
  task automatic send_interval(input logic [FIELD_W-1:0] s, input logic [FIELD_W-1:0] e,
                               input logic [FIELD_W-1:0] w, input logic lst,
                               input bit typed, input pick_t typed_pick);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    interval_start <= s;
    interval_end <= e;
    interval_weight <= w;
    last_interval <= lst;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (set_start.size() < MAX_IV) begin
      set_start = {set_start, s};
      set_end = {set_end, e};
      set_weight = {set_weight, w};
    end
    if (lst) solve_set(typed, typed_pick);
  endtask

  // Random field value: full range, a narrow range that forces overlaps,
  // or an extreme.
  function automatic logic [FIELD_W-1:0] pick_field();
    case ($urandom_range(0, 9))
      0, 1, 2: return FIELD_W'($urandom() & FIELD_MAX);
      3: return $urandom_range(0, 1) ? FIELD_MAX : '0;
      default: return FIELD_W'($urandom_range(0, 60));
    endcase
  endfunction

  task automatic send_random_set(input int unsigned size);
    logic [FIELD_W-1:0] s, e, w;
    pick_t none_typed;
    none_typed = '{idx: '0, none: 1'b0, last: 1'b0};
    for (int unsigned i = 0; i < size; i++) begin
      s = pick_field();
      case ($urandom_range(0, 9))
        0: e = FIELD_W'($urandom() & FIELD_MAX);
        1: e = (s > 0) ? FIELD_W'(s - $urandom_range(1, (s > 20) ? 20 : s)) : s;
        default: e = (s > FIELD_MAX - 30) ? FIELD_MAX : FIELD_W'(s + $urandom_range(0, 30));
      endcase
      w = ($urandom_range(0, 4) == 0) ? pick_field() : FIELD_W'($urandom_range(0, 20));
      send_interval(s, e, w, i + 1 == size, 1'b0, none_typed);
    end
  endtask

  // Result checking against the oldest expected pick.
  always @(posedge clk) begin
    if (!rst && pick_valid && !pick_stall) begin
      picks_seen <= picks_seen + 1;
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pick: idx=%0d none=%0b last=%0b",
                   picked_index, none_picked, last_pick);
      end else begin
        if (picked_index !== expected_picks[0].idx || none_picked !== expected_picks[0].none ||
            last_pick !== expected_picks[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pick mismatch: expected idx=%0d none=%0b last=%0b, got %0d %0b %0b",
                     expected_picks[0].idx, expected_picks[0].none, expected_picks[0].last,
                     picked_index, none_picked, last_pick);
        end
        void'(expected_picks.pop_front());
      end
    end
  end

  // Receiver: random stalls per pick, and one long hold-off.
  initial begin
    int unsigned d;
    @(negedge rst);
    forever begin
      if (!hold_done && picks_seen >= 20) begin
        d = 300;
        hold_done = 1'b1;
      end else begin
        d = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (d > 0) begin
        pick_stall <= 1'b1;
        repeat (d) @(posedge clk);
        pick_stall <= 1'b0;
      end
      do @(posedge clk); while (!pick_valid);
    end
  end

  // Stimulus and end of run.
  initial begin
    dir_row_t dir_rows[18];
    pick_t tp;
    int unsigned sent, set_no;
    dir_rows = '{
      // Zero weight alone: the empty choice wins the tie.
      '{s: 5, e: 9, w: 0, lst: 1, known: 1, idx: 0, none: 1},
      // All fields at their top, then a point interval of top weight.
      '{s: FIELD_MAX, e: FIELD_MAX, w: FIELD_MAX, lst: 1, known: 1, idx: 0, none: 0},
      '{s: 0, e: 0, w: FIELD_MAX, lst: 1, known: 1, idx: 0, none: 0},
      // End below start blocks only itself.
      '{s: 10, e: 3, w: 7, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 4, e: 8, w: 5, lst: 1, known: 0, idx: 0, none: 0},
      // Five disjoint equal weights: only four may be picked, smallest list wins.
      '{s: 40, e: 41, w: 1, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 10, e: 11, w: 1, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 30, e: 31, w: 1, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 0, e: 1, w: 1, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 20, e: 21, w: 1, lst: 1, known: 0, idx: 0, none: 0},
      // Shared endpoint overlaps; duplicates tie on arrival.
      '{s: 0, e: 10, w: 6, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 10, e: 20, w: 6, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 0, e: 10, w: 6, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 11, e: 20, w: 6, lst: 1, known: 0, idx: 0, none: 0},
      // Long interval against two short ones of equal total.
      '{s: 0, e: 100, w: 10, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 0, e: 50, w: 5, lst: 0, known: 0, idx: 0, none: 0},
      '{s: 51, e: 100, w: 5, lst: 1, known: 0, idx: 0, none: 0},
      '{s: 0, e: FIELD_MAX, w: 0, lst: 1, known: 1, idx: 0, none: 1}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      tp.idx = dir_rows[i].idx;
      tp.none = dir_rows[i].none;
      tp.last = 1'b1;
      send_interval(dir_rows[i].s, dir_rows[i].e, dir_rows[i].w, dir_rows[i].lst,
                    dir_rows[i].known, tp);
    end
    sent = 0;
    set_no = 0;
    while (sent < RANDOM_ITEMS) begin
      int unsigned size;
      no_gaps = (set_no % 12) >= 9;
      if ($urandom_range(0, 9) == 0) size = $urandom_range(9, 16);
      else size = $urandom_range(1, 8);
      send_random_set(size);
      sent += size;
      set_no++;
    end
    item_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("k_limited_interval_scheduling_top test passed");
    else
      $display("k_limited_interval_scheduling_top test failed");
    $finish;
  end

endmodule
